### sv/assert_macros.svh
// Assertion macros used by the checker.
// Include guard keeps repeated includes harmless.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication with reset gating.
`define CHK_IMPL(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);
// Next-cycle implication with reset gating.
`define CHK_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`endif

### sv/oaht_pkg.sv
// Shared types and constants of the open-addressed hash table.
// No dependencies.
`timescale 1ns / 1ps
package oaht_pkg;
  localparam int MAX_SIZE_LOG2 = 10;
  localparam int KEY_BITS = 64;
  localparam int VALUE_BITS = 64;
  localparam int DEPTH = 1 << MAX_SIZE_LOG2;
  localparam int AW = MAX_SIZE_LOG2;
  localparam int CW = MAX_SIZE_LOG2 + 1;

  typedef logic [1:0] mark_t;
  localparam mark_t MARK_EMPTY = 2'd0;
  localparam mark_t MARK_TOMB  = 2'd1;
  localparam mark_t MARK_OCC   = 2'd2;

  typedef logic [2:0] kind_t;
  localparam kind_t K_GET = 3'd0;
  localparam kind_t K_INS_REP = 3'd1;
  localparam kind_t K_INS_KEEP = 3'd2;
  localparam kind_t K_REP_DATA = 3'd3;
  localparam kind_t K_REMOVE = 3'd4;
  localparam kind_t K_NEXT = 3'd5;

  typedef logic [2:0] status_t;
  localparam status_t ST_NEW = 3'd0;
  localparam status_t ST_FOUND = 3'd1;
  localparam status_t ST_MISS = 3'd2;
  localparam status_t ST_FULL = 3'd3;
  localparam status_t ST_END = 3'd4;

  // Store write request from the sequencer.
  typedef struct packed {
    logic              mark_we;
    mark_t             mark;
    logic              key_we;
    logic              val_we;
    logic [AW-1:0]     addr;
    logic [KEY_BITS-1:0]   key;
    logic [31:0]       hash;
    logic [VALUE_BITS-1:0] value;
  } wr_req_t;
endpackage

### sv/oaht_store.sv
// Slot store: mark, key, hash and data memories with a registered read port.
// Depends on oaht_pkg.
`timescale 1ns / 1ps
module oaht_store (
  input  logic                           clk,
  input  logic [oaht_pkg::AW-1:0]        rd_addr,
  output oaht_pkg::mark_t                rd_mark,
  output logic [oaht_pkg::KEY_BITS-1:0]  rd_key,
  output logic [31:0]                    rd_hash,
  output logic [oaht_pkg::VALUE_BITS-1:0] rd_value,
  input  oaht_pkg::wr_req_t              wr
);
  import oaht_pkg::*;

  // Marks start undefined; the sequencer sweeps them to empty after reset.
  mark_t mark_mem [DEPTH];
  logic [KEY_BITS-1:0] key_mem [DEPTH];
  logic [31:0] hash_mem [DEPTH];
  logic [VALUE_BITS-1:0] val_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.mark_we) mark_mem[wr.addr] <= wr.mark;
    if (wr.key_we) begin
      key_mem[wr.addr] <= wr.key;
      hash_mem[wr.addr] <= wr.hash;
    end
    if (wr.val_we) val_mem[wr.addr] <= wr.value;
    rd_mark <= mark_mem[rd_addr];
    rd_key <= key_mem[rd_addr];
    rd_hash <= hash_mem[rd_addr];
    rd_value <= val_mem[rd_addr];
  end
endmodule

### sv/oaht_seq.sv
// Probe sequencer: one slot read and compare per step, then the update.
// Depends on oaht_pkg.
`timescale 1ns / 1ps
module oaht_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [3:0]                      size_log2,
  input  oaht_pkg::kind_t                 in_kind,
  input  logic [63:0]                     in_key,
  input  logic [31:0]                     in_hash_value,
  input  logic [63:0]                     in_value,
  input  logic [10:0]                     in_start_slot,
  output logic [oaht_pkg::AW-1:0]         rd_addr,
  input  oaht_pkg::mark_t                 rd_mark,
  input  logic [oaht_pkg::KEY_BITS-1:0]   rd_key,
  input  logic [31:0]                     rd_hash,
  input  logic [oaht_pkg::VALUE_BITS-1:0] rd_value,
  output oaht_pkg::wr_req_t               wr,
  output logic                            out_strobe,
  output oaht_pkg::status_t               out_status,
  output logic [63:0]                     out_key,
  output logic [63:0]                     out_value,
  output logic [31:0]                     out_hash,
  output logic [9:0]                      out_slot_index,
  output logic [10:0]                     out_used_count,
  output logic [10:0]                     out_fill_count
);
  import oaht_pkg::*;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_CHECK, S_DONE} state_t;

  state_t state_r;
  kind_t kind_r;
  logic [KEY_BITS-1:0] key_r;
  logic [31:0] hash_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [AW-1:0] idx_r, mask_r, tomb_r, slot_r, clr_r;
  logic [CW-1:0] cnt_r, used_r, fill_r;
  logic have_tomb_r;
  logic [1:0] res_r; // 0 found, 1 empty, 2 tomb, 3 full
  logic [KEY_BITS-1:0] fkey_r;
  logic [31:0] fhash_r;
  logic [VALUE_BITS-1:0] fval_r;
  logic [3:0] lg;
  logic [AW-1:0] mask_nxt, step_idx;
  logic [AW+2:0] five_i;

  localparam logic [1:0] R_FOUND = 2'd0;
  localparam logic [1:0] R_EMPTY = 2'd1;
  localparam logic [1:0] R_TOMB  = 2'd2;
  localparam logic [1:0] R_FULL  = 2'd3;

  always_comb begin
    lg = size_log2;
    if (lg < 4'd3) lg = 4'd3;
    if (lg > 4'(MAX_SIZE_LOG2)) lg = 4'(MAX_SIZE_LOG2);
    mask_nxt = AW'((CW'(1) << lg) - CW'(1));
    five_i = ({idx_r, 2'b00} + {2'b00, idx_r}) + (AW+3)'(1);
    step_idx = five_i[AW-1:0] & mask_r;
  end

  assign busy = (state_r != S_IDLE);
  assign rd_addr = idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      used_r <= '0;
      fill_r <= '0;
      out_strobe <= 1'b0;
      wr <= '0;
    end else begin
      out_strobe <= 1'b0;
      wr <= '0;
      case (state_r)
        S_CLEAR: begin
          // Sweep every slot mark to empty, one slot per cycle.
          wr.mark_we <= 1'b1;
          wr.mark <= MARK_EMPTY;
          wr.addr <= clr_r;
          clr_r <= clr_r + AW'(1);
          if (clr_r == {AW{1'b1}}) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            kind_r <= in_kind;
            key_r <= in_key[KEY_BITS-1:0];
            hash_r <= in_hash_value;
            val_r <= in_value[VALUE_BITS-1:0];
            mask_r <= mask_nxt;
            cnt_r <= '0;
            have_tomb_r <= 1'b0;
            tomb_r <= '0;
            slot_r <= '0;
            res_r <= R_FULL;
            if (in_kind == K_NEXT) begin
              // Start past the size in use: nothing to scan.
              if ({1'b0, in_start_slot} > {1'b0, CW'({1'b0, mask_nxt})}) begin
                res_r <= R_EMPTY;
                state_r <= S_DONE;
              end else begin
                idx_r <= in_start_slot[AW-1:0];
                state_r <= S_READ;
              end
            end else if (in_kind > K_NEXT) begin
              res_r <= R_EMPTY;
              state_r <= S_DONE;
            end else begin
              idx_r <= in_hash_value[AW-1:0] & mask_nxt;
              state_r <= S_READ;
            end
          end
        end
        S_READ: state_r <= S_CHECK;
        S_CHECK: begin
          if (kind_r == K_NEXT) begin
            if (rd_mark == MARK_OCC) begin
              res_r <= R_FOUND;
              slot_r <= idx_r;
              fkey_r <= rd_key; fhash_r <= rd_hash; fval_r <= rd_value;
              state_r <= S_DONE;
            end else if (idx_r == mask_r) begin
              res_r <= R_EMPTY;
              state_r <= S_DONE;
            end else begin
              idx_r <= idx_r + AW'(1);
              state_r <= S_READ;
            end
          end else if (rd_mark == MARK_EMPTY) begin
            res_r <= R_EMPTY; slot_r <= idx_r; state_r <= S_DONE;
          end else if (rd_mark == MARK_OCC && rd_key == key_r) begin
            res_r <= R_FOUND; slot_r <= idx_r;
            fkey_r <= rd_key; fhash_r <= rd_hash; fval_r <= rd_value;
            state_r <= S_DONE;
          end else begin
            if (rd_mark == MARK_TOMB) begin
              have_tomb_r <= 1'b1; tomb_r <= idx_r;
            end
            if (cnt_r[AW-1:0] == mask_r) begin
              if (rd_mark == MARK_TOMB || have_tomb_r) begin
                res_r <= R_TOMB;
                slot_r <= (rd_mark == MARK_TOMB) ? idx_r : tomb_r;
              end else begin
                res_r <= R_FULL; slot_r <= '0;
              end
              state_r <= S_DONE;
            end else begin
              cnt_r <= cnt_r + CW'(1);
              idx_r <= step_idx;
              state_r <= S_READ;
            end
          end
        end
        S_DONE: begin
          state_r <= S_IDLE;
          out_strobe <= 1'b1;
          out_key <= '0; out_value <= '0; out_hash <= hash_r;
          out_slot_index <= 10'(slot_r);
          out_status <= ST_MISS;
          out_used_count <= used_r;
          out_fill_count <= fill_r;
          wr.addr <= slot_r;
          wr.key <= key_r; wr.hash <= hash_r; wr.value <= val_r;
          if (res_r == R_FOUND) begin
            out_status <= ST_FOUND;
            out_key <= 64'(fkey_r); out_value <= 64'(fval_r); out_hash <= fhash_r;
          end
          if (kind_r == K_NEXT) begin
            if (res_r != R_FOUND) begin
              out_status <= ST_END; out_slot_index <= '0;
            end
          end else if (kind_r == K_INS_REP || kind_r == K_INS_KEEP) begin
            if (res_r == R_FOUND) begin
              if (kind_r == K_INS_REP) begin
                wr.key_we <= 1'b1; wr.val_we <= 1'b1;
              end
            end else if (res_r == R_FULL) begin
              out_status <= ST_FULL;
            end else begin
              out_status <= ST_NEW;
              wr.mark_we <= 1'b1; wr.mark <= MARK_OCC;
              wr.key_we <= 1'b1; wr.val_we <= 1'b1;
              used_r <= used_r + CW'(1);
              out_used_count <= used_r + CW'(1);
              if (res_r == R_EMPTY) begin
                fill_r <= fill_r + CW'(1);
                out_fill_count <= fill_r + CW'(1);
              end
            end
          end else if (kind_r == K_REP_DATA) begin
            if (res_r == R_FOUND) wr.val_we <= 1'b1;
          end else if (kind_r == K_REMOVE) begin
            if (res_r == R_FOUND) begin
              wr.mark_we <= 1'b1; wr.mark <= MARK_TOMB;
              used_r <= used_r - CW'(1);
              out_used_count <= used_r - CW'(1);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

### sv/open_addressed_hash_table.sv
// Top level of the open-addressed hash table: sequencer plus slot store.
// Depends on oaht_pkg, oaht_seq and oaht_store.
//
// Usage: raise start with the operation fields while busy is low; the
// operation is taken at that edge and busy rises. The table probes one
// slot per step (registered memory read, then compare) stepping
// index = 5*index+1 within the size in use, up to size probes when the
// table is full. next-occupied scans linearly, one slot per step; a start
// slot past the size in use and the unused kinds skip the probe and go
// straight to the result. out_strobe marks the single result for one
// cycle; the receiver cannot stall, so it must take it then. busy falls in
// the same cycle the result is shown, so the next operation can be taken
// at the edge ending it; the write to the store lands at that same edge,
// ahead of the next read. Reset zeroes the counts and sets size_log2 to 3;
// after reset busy stays high while a sweep marks every slot empty. Write
// cfg_size_log2 only while idle; values outside 3..10 are clamped.
`timescale 1ns / 1ps
module open_addressed_hash_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_size_log2,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [63:0] in_key,
  input  logic [31:0] in_hash_value,
  input  logic [63:0] in_value,
  input  logic [10:0] in_start_slot,
  output logic        out_strobe,
  output logic [2:0]  out_status,
  output logic [63:0] out_key,
  output logic [63:0] out_value,
  output logic [31:0] out_hash,
  output logic [9:0]  out_slot_index,
  output logic [10:0] out_used_count,
  output logic [10:0] out_fill_count
);
  import oaht_pkg::*;

  logic [3:0] size_log2_r;
  logic [AW-1:0] rd_addr;
  mark_t rd_mark;
  logic [KEY_BITS-1:0] rd_key;
  logic [31:0] rd_hash;
  logic [VALUE_BITS-1:0] rd_value;
  wr_req_t wr;

  always_ff @(posedge clk) begin
    if (!rst_n) size_log2_r <= 4'd3;
    else if (cfg_we) size_log2_r <= cfg_size_log2;
  end

  oaht_seq u_seq (
    .clk, .rst_n, .start, .busy, .size_log2(size_log2_r),
    .in_kind, .in_key, .in_hash_value, .in_value, .in_start_slot,
    .rd_addr, .rd_mark, .rd_key, .rd_hash, .rd_value, .wr,
    .out_strobe, .out_status, .out_key, .out_value, .out_hash,
    .out_slot_index, .out_used_count, .out_fill_count
  );

  oaht_store u_store (
    .clk, .rd_addr, .rd_mark, .rd_key, .rd_hash, .rd_value, .wr
  );
endmodule

### sv/oaht_checker.sv
// Port-level checker for the hash table, bound to the top level.
// Depends on oaht_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module oaht_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic [2:0]  out_status,
  input logic [10:0] out_used_count,
  input logic [10:0] out_fill_count
);
  import oaht_pkg::*;

  `CHK_NEXT(a_take_busy, clk, rst_n, start && !busy, busy, "busy did not rise")
  `CHK_IMPL(a_strobe_idle, clk, rst_n, out_strobe, !busy, "busy high with result")
  `CHK_NEXT(a_strobe_one, clk, rst_n, out_strobe, !out_strobe, "result repeated")
  `CHK_IMPL(a_counts, clk, rst_n, out_strobe, out_used_count <= out_fill_count, "used above fill")
  `CHK_IMPL(a_status, clk, rst_n, out_strobe, out_status <= ST_END, "bad status")
endmodule

bind open_addressed_hash_table oaht_checker u_chk (
  .clk, .rst_n, .start, .busy, .out_strobe, .out_status,
  .out_used_count, .out_fill_count
);

### bench/open_addressed_hash_table_tb.sv
// Self-checking bench for open_addressed_hash_table: random and directed table
// operations checked against a behavioral model of the slot store.
// Depends on oaht_pkg and the open_addressed_hash_table RTL.
`timescale 1ns / 1ps
module open_addressed_hash_table_tb;
  import oaht_pkg::*;

  // Probe outcomes of the model.
  localparam int P_FOUND = 0;
  localparam int P_EMPTY = 1;
  localparam int P_TOMB  = 2;
  localparam int P_FULL  = 3;

  typedef struct {
    logic        is_cfg;
    logic [3:0]  cfg_val;
    logic        wait_idle;
    kind_t       kind;
    logic [63:0] key;
    logic [31:0] hash;
    logic [63:0] value;
    logic [10:0] start_slot;
  } op_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] key;
    logic [63:0] value;
    logic [31:0] hash;
    logic [9:0]  slot;
    logic [10:0] used;
    logic [10:0] fill;
  } reply_t;

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [3:0] cfg_size_log2 = 4'd3;
  logic start = 0, busy;
  logic [2:0] in_kind = '0;
  logic [63:0] in_key = '0, in_value = '0;
  logic [31:0] in_hash_value = '0;
  logic [10:0] in_start_slot = '0;
  logic out_strobe;
  logic [2:0] out_status;
  logic [63:0] out_key, out_value;
  logic [31:0] out_hash;
  logic [9:0] out_slot_index;
  logic [10:0] out_used_count, out_fill_count;

  open_addressed_hash_table dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Model state
  mark_t       m_mark [DEPTH];
  logic [63:0] m_key [DEPTH];
  logic [31:0] m_hash [DEPTH];
  logic [63:0] m_val [DEPTH];
  int          m_used, m_fill, m_log2;

  op_t    pending_ops[$];
  op_t    expected_ops[$];   // driven, not yet accepted
  reply_t expected_replies[$];
  int errors = 0, n_ops = 0, n_results = 0, n_cfg = 0;
  bit stim_done = 0;
  bit took;
  int idle_cycles = 0;

  function automatic reply_t apply_op(op_t op);
    reply_t r;
    int mask, i, tomb, s, res;
    bit have_tomb;
    mask = (1 << m_log2) - 1;
    r.status = ST_MISS; r.key = 0; r.value = 0; r.hash = op.hash; r.slot = 0;
    if (op.kind <= K_REMOVE) begin
      i = op.hash & mask; have_tomb = 0; tomb = 0; res = P_FULL;
      for (int n = 0; n <= mask; n++) begin
        if (m_mark[i] == MARK_EMPTY) begin res = P_EMPTY; break; end
        if (m_mark[i] == MARK_OCC && m_key[i] == op.key) begin res = P_FOUND; break; end
        if (m_mark[i] == MARK_TOMB) begin have_tomb = 1; tomb = i; end
        i = (5 * i + 1) & mask;
      end
      if (res == P_FULL && have_tomb) begin res = P_TOMB; i = tomb; end
      if (res == P_FULL) i = 0;
      r.slot = i;
      if (res == P_FOUND) begin
        r.status = ST_FOUND; r.key = m_key[i]; r.value = m_val[i]; r.hash = m_hash[i];
      end
      case (op.kind)
        K_INS_REP, K_INS_KEEP: begin
          if (res == P_FOUND) begin
            if (op.kind == K_INS_REP) begin
              m_key[i] = op.key; m_hash[i] = op.hash; m_val[i] = op.value;
            end
          end else if (res == P_FULL) begin
            r.status = ST_FULL;
          end else begin
            if (res == P_EMPTY) m_fill++;
            m_used++;
            m_mark[i] = MARK_OCC; m_key[i] = op.key; m_hash[i] = op.hash;
            m_val[i] = op.value; r.status = ST_NEW;
          end
        end
        K_REP_DATA: if (res == P_FOUND) m_val[i] = op.value;
        K_REMOVE: if (res == P_FOUND) begin
          m_mark[i] = MARK_TOMB; m_key[i] = 0; m_hash[i] = 0; m_val[i] = 0; m_used--;
        end
        default: ;
      endcase
    end else if (op.kind == K_NEXT) begin
      r.status = ST_END;
      for (s = op.start_slot; s < (1 << m_log2); s++)
        if (m_mark[s] == MARK_OCC) begin
          r.status = ST_FOUND; r.slot = s; r.key = m_key[s];
          r.value = m_val[s]; r.hash = m_hash[s];
          break;
        end
    end
    r.used = m_used; r.fill = m_fill;
    return r;
  endfunction

  function automatic void push_op(kind_t k, logic [63:0] key, logic [31:0] h,
                                  logic [63:0] v, logic [10:0] ss);
    op_t op;
    op.is_cfg = 0; op.wait_idle = 0; op.cfg_val = 0;
    op.kind = k; op.key = key; op.hash = h; op.value = v; op.start_slot = ss;
    pending_ops.push_back(op);
  endfunction

  function automatic void push_cfg(logic [3:0] v);
    op_t op;
    op.is_cfg = 1; op.wait_idle = 1; op.cfg_val = v;
    op.kind = K_GET; op.key = 0; op.hash = 0; op.value = 0; op.start_slot = 0;
    pending_ops.push_back(op);
  endfunction

  function automatic void push_drain();
    op_t op;
    op.is_cfg = 0; op.wait_idle = 1; op.cfg_val = 0;
    op.kind = K_GET; op.key = 0; op.hash = 0; op.value = 0; op.start_slot = 0;
    pending_ops.push_back(op);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int short_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Random phase: a small key pool drives hits, tombstones and full tables.
  function automatic void random_phase(int count, int pool);
    logic [63:0] k;
    kind_t kd;
    int sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) kd = K_INS_REP;
      else if (sel < 45) kd = K_INS_KEEP;
      else if (sel < 60) kd = K_GET;
      else if (sel < 68) kd = K_REP_DATA;
      else if (sel < 85) kd = K_REMOVE;
      else if (sel < 95) kd = K_NEXT;
      else kd = kind_t'($urandom_range(6, 7));
      if ($urandom_range(0, 9) == 0) k = rand64();
      else k = 64'($urandom_range(1, pool)) ^ {$urandom_range(0, 1) ? 32'hffff_ffff : 32'h0, 32'h0};
      push_op(kd, k, ($urandom_range(0, 3) == 0) ? $urandom : k[31:0] * 32'h9e37_79b9,
              rand64(), $urandom_range(0, 3) == 0 ? 11'($urandom) : 11'($urandom_range(0, 16)));
    end
  endfunction

  // Driver
  int gap = 0;
  always @(negedge clk) begin
    op_t op;
    if (rst_n) begin
      if (cfg_we) cfg_we <= 0;
      if (start && !took) begin
        // hold the transaction until it is taken
      end else if (gap > 0) begin
        gap <= gap - 1;
        if (start) start <= 0;
      end else if (pending_ops.size() > 0) begin
        op = pending_ops[0];
        if (op.wait_idle) begin
          if (start) start <= 0;
          if (expected_replies.size() == 0 && !busy && idle_cycles >= 4) begin
            void'(pending_ops.pop_front());
            if (op.is_cfg) begin
              cfg_we <= 1; cfg_size_log2 <= op.cfg_val;
              m_log2 = op.cfg_val < 3 ? 3 :
                       (op.cfg_val > MAX_SIZE_LOG2 ? MAX_SIZE_LOG2 : op.cfg_val);
              n_cfg++;
            end
            gap <= 1;
          end
        end else begin
          void'(pending_ops.pop_front());
          in_kind <= op.kind; in_key <= op.key; in_hash_value <= op.hash;
          in_value <= op.value; in_start_slot <= op.start_slot;
          start <= 1;
          expected_ops.push_back(op);
          gap <= short_gap();
        end
      end else begin
        if (start) start <= 0;
        stim_done <= 1;
      end
    end
  end

  // Acceptance, monitor, watchdog
  int stall = 0;
  always @(posedge clk) begin
    reply_t got, want;
    took = 0;
    if (!rst_n) begin
      stall = 0;
    end else begin
      stall++;
      if (start && !busy) begin
        took = 1; stall = 0; n_ops++;
        expected_replies.push_back(apply_op(expected_ops.pop_front()));
      end
      idle_cycles = (busy || start || expected_replies.size() > 0) ? 0 : idle_cycles + 1;
      if (out_strobe) begin
        stall = 0; n_results++;
        got.status = out_status; got.key = out_key; got.value = out_value;
        got.hash = out_hash; got.slot = out_slot_index;
        got.used = out_used_count; got.fill = out_fill_count;
        if (expected_replies.size() == 0) begin
          errors++;
          $display("%0t: unexpected result status %0d key %h", $realtime, out_status, out_key);
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch exp st=%0d k=%h v=%h h=%h s=%0d u=%0d f=%0d", $realtime,
                     want.status, want.key, want.value, want.hash, want.slot, want.used,
                     want.fill);
            $display("%0t:          got st=%0d k=%h v=%h h=%h s=%0d u=%0d f=%0d", $realtime,
                     got.status, got.key, got.value, got.hash, got.slot, got.used, got.fill);
          end
        end
      end
      if (stall > 20000) begin
        $display("watchdog: no transaction for %0d cycles", stall);
        $display("open_addressed_hash_table regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int tail;
    foreach (m_mark[i]) begin
      m_mark[i] = MARK_EMPTY; m_key[i] = 0; m_hash[i] = 0; m_val[i] = 0;
    end
    m_used = 0; m_fill = 0; m_log2 = 3;

    // Directed: smallest table, every operation, extremes, fill to full.
    push_op(K_GET, 64'd1, 32'h0, 64'd0, 11'd0);
    push_op(K_NEXT, 64'd1, 32'h0, 64'd0, 11'd0);
    push_op(K_INS_REP, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 11'd0);
    push_op(K_INS_KEEP, 64'hffff_ffff_ffff_ffff, 32'h0, 64'h0, 11'd0);
    push_op(K_INS_REP, 64'hffff_ffff_ffff_ffff, 32'h1234_5678, 64'h55, 11'd0);
    push_op(K_REP_DATA, 64'hffff_ffff_ffff_ffff, 32'h0, 64'haa, 11'd0);
    push_op(K_REP_DATA, 64'd7, 32'h0, 64'haa, 11'd0);
    push_op(K_INS_REP, 64'd0, 32'd3, 64'd9, 11'd0);        // zero key
    for (int k = 1; k <= 7; k++) push_op(K_INS_KEEP, 64'(k) << 40, 32'(k), 64'(k), 11'd0);
    push_op(K_INS_REP, 64'd99, 32'd5, 64'd1, 11'd0);       // full
    push_op(K_GET, 64'd99, 32'd5, 64'd0, 11'd0);
    push_op(K_REMOVE, 64'(3) << 40, 32'd3, 64'd0, 11'd0);
    push_op(K_REMOVE, 64'(3) << 40, 32'd3, 64'd0, 11'd0);
    push_op(K_INS_REP, 64'd99, 32'd5, 64'd1, 11'd0);       // reuse tombstone
    push_op(K_NEXT, 64'd1, 32'h0, 64'd0, 11'd7);
    push_op(K_NEXT, 64'd1, 32'h0, 64'd0, 11'd8);
    push_op(K_NEXT, 64'd1, 32'h0, 64'd0, 11'h7ff);
    push_op(kind_t'(6), 64'd1, 32'h0, 64'd0, 11'd0);
    push_op(kind_t'(7), 64'd1, 32'h0, 64'd0, 11'd0);
    push_drain();
    random_phase(200, 12);
    push_cfg(4'd10);
    random_phase(300, 600);
    push_drain();
    random_phase(100, 40);
    push_cfg(4'd0);           // clamps up
    random_phase(200, 10);
    push_cfg(4'd15);          // clamps down
    random_phase(200, 2000);
    push_cfg(4'd5);
    random_phase(350, 50);
    push_cfg(4'd4);
    random_phase(350, 20);

    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1;

    wait (stim_done && expected_replies.size() == 0 && expected_ops.size() == 0);
    tail = 0;
    while (tail < 200 && (busy || out_strobe || tail < 20)) begin
      @(posedge clk);
      tail++;
    end
    $display("ran %0d operations over %0d size settings, checked %0d results",
             n_ops, n_cfg, n_results);
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("open_addressed_hash_table regression: pass");
    end else begin
      $display("open_addressed_hash_table regression: fail");
    end
    $finish;
  end
endmodule
